// ===== sv/ipdac_pkg.sv =====
// Package for the incremental PD accelerator controller: fixed-point format,
// configuration register indexes, mode and step-action codes.
// No dependencies.
package ipdac_pkg;

  // Fixed-point format of every value: signed, FRAC_BITS fractional bits.
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 16;

  // Width of the configuration write port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_P_GAIN         = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_D_GAIN_OVER_DT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REGULAR_POS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POS        = 3'd4;

  // Control modes. The unused code behaves as fixed mode.
  localparam logic [1:0] MODE_FIXED    = 2'd0;
  localparam logic [1:0] MODE_PD       = 2'd1;
  localparam logic [1:0] MODE_STEP     = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Step actions.
  localparam logic [1:0] ACT_KEEP     = 2'd0;
  localparam logic [1:0] ACT_INCREASE = 2'd1;
  localparam logic [1:0] ACT_DECREASE = 2'd2;
  localparam logic [1:0] ACT_FAILURE  = 2'd3;

  // Step size of 0.1, rounded to the nearest code.
  localparam int unsigned STEP_TENTH = ((1 << FRAC_BITS) + 5) / 10;

  // Reset value of the upper clamp: the largest positive code.
  localparam logic signed [DATA_W-1:0] MAX_POS_RESET = {1'b0, {(DATA_W-1){1'b1}}};

endpackage

// ===== sv/incremental_pd_accel_controller_core.sv =====
// Top level of the incremental PD accelerator controller.
// Depends on ipdac_pkg for the number format, register indexes and codes.
//
// Usage:
//   Input words (velocity_error_i, step_action_i, enter_flag_i) arrive on a
//   valid/ready channel and are taken at a clock edge where in_valid_i and
//   in_ready_o are both high. Every input word produces exactly one result
//   word, accel_command_o, on the out_valid_o/out_ready_i channel.
//   The input word is first captured in an input register. Once the result
//   register is free it is processed in one pass (two parallel multiplies,
//   rounding, the accumulator add and the clamp) and lands in the result
//   register, where it is shown. There are two register stages, and one word
//   per cycle is sustained while out_ready_i stays high; the accumulator
//   and error history are updated in the same cycle as the result register,
//   so the next word sees them at once.
//   When the receiver stalls, the result register holds its word and the
//   input register can still take one more word; only when both are full
//   does in_ready_o drop. No word is lost or repeated.
//   Configuration is written over cfg_we_i/cfg_addr_i/cfg_wdata_i without a
//   handshake; the user must write it only while the block is idle (not enforced).
//   Reset clears both valid flags, the accumulator, the error history and the
//   configuration registers (the maximum position resets to the largest code).
module incremental_pd_accel_controller_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port
  input  logic                                   cfg_we_i,
  input  logic [ipdac_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [ipdac_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [ipdac_pkg::DATA_W-1:0]    velocity_error_i,
  input  logic [1:0]                             step_action_i,
  input  logic                                   enter_flag_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ipdac_pkg::DATA_W-1:0]    accel_command_o
);
  import ipdac_pkg::*;

  // Widths of the PD datapath.
  localparam int unsigned D1_W   = DATA_W + 1;    // e0 - e1
  localparam int unsigned D2_W   = DATA_W + 2;    // e0 - 2*e1 + e2
  localparam int unsigned PP_W   = DATA_W + D1_W; // P product
  localparam int unsigned DP_W   = DATA_W + D2_W; // D product
  localparam int unsigned SUM_W  = DP_W + 1;      // sum of both products
  localparam int unsigned ACC_W  = SUM_W + 1;     // accumulator plus increment

  localparam logic signed [SUM_W-1:0] PD_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] STEP_W  = ACC_W'(STEP_TENTH);

  // Configuration registers.
  logic [1:0]                control_mode_q;
  logic signed [DATA_W-1:0]  p_gain_q;
  logic signed [DATA_W-1:0]  d_gain_over_dt_q;
  logic signed [DATA_W-1:0]  regular_pos_q;
  logic signed [DATA_W-1:0]  max_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_mode_q   <= MODE_FIXED;
      p_gain_q         <= '0;
      d_gain_over_dt_q <= '0;
      regular_pos_q    <= '0;
      max_pos_q        <= MAX_POS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CONTROL_MODE:   control_mode_q   <= cfg_wdata_i[1:0];
        CFG_P_GAIN:         p_gain_q         <= cfg_wdata_i;
        CFG_D_GAIN_OVER_DT: d_gain_over_dt_q <= cfg_wdata_i;
        CFG_REGULAR_POS:    regular_pos_q    <= cfg_wdata_i;
        CFG_MAX_POS:        max_pos_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register and pipeline flow control.
  logic                      s1_valid_q;
  logic signed [DATA_W-1:0]  s1_error_q;
  logic [1:0]                s1_action_q;
  logic                      s1_enter_q;
  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  cmd_q;
  logic signed [DATA_W-1:0]  cmd_d;
  logic                      s1_adv;
  logic                      in_fire;

  // The result register frees up when empty or when its word is taken.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_error_q  <= velocity_error_i;
      s1_action_q <= step_action_i;
      s1_enter_q  <= enter_flag_i;
    end
  end

  // Controller state.
  logic signed [DATA_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0]  prev_error_q;
  logic signed [DATA_W-1:0]  prev_prev_error_q;
  logic                      proc;

  assign proc = s1_valid_q && s1_adv;

  // PD increment: P*(e0-e1) + (D/dt)*(e0-2*e1+e2), rounded half up.
  logic signed [D1_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic signed [PP_W-1:0]   p_prod;
  logic signed [DP_W-1:0]   d_prod;
  logic signed [SUM_W-1:0]  pd_sum;
  logic signed [SUM_W-1:0]  pd_inc;

  assign d1     = D1_W'(s1_error_q) - D1_W'(prev_error_q);
  assign d2     = D2_W'(s1_error_q) - (D2_W'(prev_error_q) <<< 1) + D2_W'(prev_prev_error_q);
  assign p_prod = PP_W'(p_gain_q) * PP_W'(d1);
  assign d_prod = DP_W'(d_gain_over_dt_q) * DP_W'(d2);
  assign pd_sum = SUM_W'(p_prod) + SUM_W'(d_prod) + PD_HALF;
  assign pd_inc = pd_sum >>> FRAC_BITS;

  // Accumulator update and clamp.
  logic signed [DATA_W-1:0] acc_base;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  lo_clamped;
  logic signed [ACC_W-1:0]  clamped;
  logic                     mode_active;

  assign acc_base    = s1_enter_q ? regular_pos_q : acc_q;
  assign mode_active = (control_mode_q == MODE_PD) || (control_mode_q == MODE_STEP);

  always_comb begin
    acc_sum = ACC_W'(acc_base);
    if (control_mode_q == MODE_PD) begin
      acc_sum = ACC_W'(acc_base) + ACC_W'(pd_inc);
    end else begin
      unique case (s1_action_q)
        ACT_KEEP:     acc_sum = ACC_W'(acc_base);
        ACT_INCREASE: acc_sum = ACC_W'(acc_base) + STEP_W;
        ACT_DECREASE: acc_sum = ACC_W'(acc_base) - STEP_W;
        ACT_FAILURE:  acc_sum = ACC_W'(acc_base) + ACC_W'(regular_pos_q);
        default:      acc_sum = ACC_W'(acc_base);
      endcase
    end
  end

  // Lower clamp first, then upper, so the maximum wins if the two cross.
  assign lo_clamped = (acc_sum < ACC_W'(regular_pos_q)) ? ACC_W'(regular_pos_q) : acc_sum;
  assign clamped    = (lo_clamped > ACC_W'(max_pos_q)) ? ACC_W'(max_pos_q) : lo_clamped;

  always_comb begin
    if (mode_active) begin
      acc_d = DATA_W'(clamped);
      cmd_d = DATA_W'(clamped);
    end else begin
      acc_d = acc_base;
      cmd_d = regular_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q             <= '0;
      prev_error_q      <= '0;
      prev_prev_error_q <= '0;
    end else if (proc) begin
      acc_q             <= acc_d;
      prev_error_q      <= s1_error_q;
      prev_prev_error_q <= prev_error_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accel_command_o = cmd_q;

  // Checks on the pipeline and datapath.
  a_s1_holds_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("input register lost a word while the result register was full");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (prev_error_q == $past(s1_error_q)) && (prev_prev_error_q == $past(prev_error_q)))
    else $error("error history did not shift with a processed word");

  a_fixed_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !mode_active) |=> (cmd_q == $past(regular_pos_q)))
    else $error("fixed mode result is not the regular position");

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && mode_active && (regular_pos_q <= max_pos_q)) |=>
      ((cmd_q >= $past(regular_pos_q)) && (cmd_q <= $past(max_pos_q)) && (acc_q == cmd_q)))
    else $error("active mode result outside the clamp range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for incremental_pd_accel_controller_core: fixed, PD
// and step modes, clamping, enter loads and backpressure. Depends on ipdac_pkg
// and the core RTL; commands are predicted in the bench and compared in order.
module testbench;
  import ipdac_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Two register stages in the core; a few more cycles are allowed at the end.
  localparam int unsigned TAIL_CYCLES = 6;
  // Long receiver hold-off, long enough to back the block up to its input.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned WORDS_PER_PHASE = 90;

  // Clock, reset and every block input start at a known value.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = CFG_CONTROL_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [DATA_W-1:0] velocity_error_i = '0;
  logic [1:0] step_action_i = ACT_KEEP;
  logic enter_flag_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] accel_command_o;

  incremental_pd_accel_controller_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .velocity_error_i (velocity_error_i),
    .step_action_i    (step_action_i),
    .enter_flag_i     (enter_flag_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accel_command_o  (accel_command_o)
  );

  // Mirror of the configuration registers, kept in step with every write.
  logic [1:0] mode_q = MODE_FIXED;
  logic signed [DATA_W-1:0] p_gain_q = '0;
  logic signed [DATA_W-1:0] d_gain_q = '0;
  logic signed [DATA_W-1:0] regular_pos_q = '0;
  logic signed [DATA_W-1:0] max_pos_q = MAX_POS_RESET;

  // Mirror of the controller state: accumulator and the two older errors.
  logic signed [DATA_W-1:0] accel_q = '0;
  logic signed [DATA_W-1:0] err1_q = '0;
  logic signed [DATA_W-1:0] err2_q = '0;

  // Commands the block still owes, oldest first.
  logic signed [DATA_W-1:0] pending_commands[$];

  int unsigned words_sent = 0;
  int unsigned commands_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Idling controls shared by the sender, the receiver and the test tasks.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d commands still owed", $time,
               cycle_count, pending_commands.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Lower clamp first, then the upper one, so an inverted pair yields max_pos.
  function automatic longint clamp_position(longint x);
    if (x < longint'(regular_pos_q)) x = longint'(regular_pos_q);
    if (x > longint'(max_pos_q)) x = longint'(max_pos_q);
    return x;
  endfunction

  // Works out the command for one word and advances the mirrored state.
  function automatic logic signed [DATA_W-1:0] next_command(
    logic signed [DATA_W-1:0] err, logic [1:0] act, logic enter);
    logic signed [DATA_W-1:0] cmd;
    longint x, d1, d2, sum;
    longint half, tenth;
    half = longint'(1) << (FRAC_BITS - 1);
    tenth = longint'(STEP_TENTH);
    if (enter) accel_q = regular_pos_q;
    x = longint'(accel_q);
    case (mode_q)
      MODE_PD: begin
        d1 = longint'(err) - longint'(err1_q);
        d2 = longint'(err) - 2 * longint'(err1_q) + longint'(err2_q);
        sum = longint'(p_gain_q) * d1 + longint'(d_gain_q) * d2;
        // Round to nearest with ties going up: add half, then floor.
        x = clamp_position(x + ((sum + half) >>> FRAC_BITS));
        accel_q = x[DATA_W-1:0];
        cmd = accel_q;
      end
      MODE_STEP: begin
        case (act)
          ACT_INCREASE: x = x + tenth;
          ACT_DECREASE: x = x - tenth;
          ACT_FAILURE:  x = x + longint'(regular_pos_q);
          default:      x = x;
        endcase
        x = clamp_position(x);
        accel_q = x[DATA_W-1:0];
        cmd = accel_q;
      end
      // Fixed mode and the unused code both show the regular position.
      default: cmd = regular_pos_q;
    endcase
    // The error history shifts in every mode.
    err2_q = err1_q;
    err1_q = err;
    return cmd;
  endfunction

  // Compare every accepted command with the oldest one still owed.
  always @(posedge clk_i) begin
    logic signed [DATA_W-1:0] expected;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_commands.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected command word: expected none, actual %0d", $time,
                 accel_command_o);
      end else begin
        expected = pending_commands.pop_front();
        commands_checked++;
        if (accel_command_o !== expected) begin
          mismatch_count++;
          $display("%0t: accel_command mismatch: expected %0d, actual %0d", $time,
                   expected, accel_command_o);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when a test asks for it.
  // The hold-off is counted here, so the sender keeps offering words meanwhile.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Offers one word, waits for the handshake and records the owed command.
  // Valid stays high into the next word when no gap is drawn.
  task automatic send_word(logic signed [DATA_W-1:0] err, logic [1:0] act, logic enter);
    int unsigned gap;
    gap = tx_idle_en ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    velocity_error_i <= err;
    step_action_i <= act;
    enter_flag_i <= enter;
    do @(posedge clk_i); while (!in_ready_o);
    pending_commands.push_back(next_command(err, act, enter));
    words_sent++;
  endtask

  // Drops valid and waits until every owed command has been seen, then lets
  // the pipeline settle before anything else is touched.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write enable stays high across consecutive writes; write_config lowers it.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CONTROL_MODE:   mode_q = val[1:0];
      CFG_P_GAIN:         p_gain_q = val;
      CFG_D_GAIN_OVER_DT: d_gain_q = val;
      CFG_REGULAR_POS:    regular_pos_q = val;
      CFG_MAX_POS:        max_pos_q = val;
      default: ;
    endcase
  endtask

  task automatic write_config(logic [1:0] mode, logic signed [DATA_W-1:0] p,
                              logic signed [DATA_W-1:0] d,
                              logic signed [DATA_W-1:0] reg_pos,
                              logic signed [DATA_W-1:0] max_p);
    wait_idle();
    write_reg(CFG_CONTROL_MODE, {{(CFG_DATA_W-2){1'b0}}, mode});
    write_reg(CFG_P_GAIN, p);
    write_reg(CFG_D_GAIN_OVER_DT, d);
    write_reg(CFG_REGULAR_POS, reg_pos);
    write_reg(CFG_MAX_POS, max_p);
    cfg_we_i <= 1'b0;
  endtask

  // Errors: mostly small, often full range, sometimes right at the extremes.
  function automatic logic signed [DATA_W-1:0] random_error();
    int unsigned r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom);
    if (r == 3) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    v = int'($urandom_range(0, 1023)) - 512;
    return 16'(v);
  endfunction

  // Gains: mostly within a few units, now and then anywhere in range.
  function automatic logic signed [DATA_W-1:0] random_gain();
    int v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    v = int'($urandom_range(0, 1535)) - 768;
    return 16'(v);
  endfunction

  // Right after reset the block is in fixed mode with a regular position of 0.
  task automatic test_reset_defaults();
    send_word(16'sh7fff, ACT_INCREASE, 1'b1);
    send_word(16'sh8000, ACT_FAILURE, 1'b0);
  endtask

  // Fixed mode and the unused mode code ignore the step action and the errors.
  task automatic test_fixed_modes();
    write_config(MODE_FIXED, 16'sd256, 16'sd256, 16'sh8000, 16'sh7fff);
    send_word(16'sd1000, ACT_INCREASE, 1'b0);
    send_word(-16'sd1000, ACT_DECREASE, 1'b1);
    write_config(MODE_RESERVED, 16'sd256, -16'sd256, 16'sh7fff, 16'sh8000);
    send_word(16'sd5, ACT_FAILURE, 1'b0);
    send_word(16'sh0000, ACT_KEEP, 1'b1);
  endtask

  task automatic test_pd_directed();
    // Unity proportional gain: clamp at the regular position and at the top.
    write_config(MODE_PD, 16'sd256, 16'sd0, 16'sd0, MAX_POS_RESET);
    send_word(16'sd100, ACT_KEEP, 1'b1);
    send_word(16'sd300, ACT_KEEP, 1'b0);
    send_word(16'sh8000, ACT_KEEP, 1'b0);
    send_word(16'sh7fff, ACT_KEEP, 1'b0);
    // Gain of one half, so unit error steps land exactly on rounding ties.
    write_config(MODE_PD, 16'sd128, 16'sd0, -16'sd1000, 16'sd1000);
    send_word(16'sd1, ACT_KEEP, 1'b1);
    send_word(16'sd0, ACT_KEEP, 1'b0);
    // Extreme gains with the error swinging between its extremes.
    write_config(MODE_PD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_word(16'sh7fff, ACT_KEEP, 1'b0);
    send_word(16'sh8000, ACT_KEEP, 1'b0);
    // Regular position above the maximum: the maximum wins.
    write_config(MODE_PD, 16'sd256, 16'sd256, 16'sd500, -16'sd500);
    send_word(16'sd42, ACT_KEEP, 1'b1);
  endtask

  task automatic test_step_directed();
    write_config(MODE_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd100);
    send_word(16'sd0, ACT_INCREASE, 1'b1);
    send_word(16'sd0, ACT_INCREASE, 1'b0);
    send_word(16'sd0, ACT_INCREASE, 1'b0);
    send_word(16'sd0, ACT_INCREASE, 1'b0);
    send_word(16'sd0, ACT_DECREASE, 1'b0);
    send_word(16'sd0, ACT_KEEP, 1'b0);
    // A trial failure adds the regular position; after enter a decrease is held by the lower clamp.
    write_config(MODE_STEP, 16'sd0, 16'sd0, 16'sd40, 16'sd200);
    send_word(16'sd0, ACT_FAILURE, 1'b1);
    send_word(16'sd0, ACT_FAILURE, 1'b0);
    send_word(16'sd0, ACT_FAILURE, 1'b0);
    send_word(16'sd0, ACT_DECREASE, 1'b1);
  endtask

  // Random phases, each with its own setting; the first two sit at extremes.
  task automatic test_random_phases();
    logic [1:0] mode;
    logic signed [DATA_W-1:0] reg_pos, max_p;
    logic [1:0] act;
    logic enter;
    int r, top;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      r = $urandom_range(0, 9);
      mode = (r < 4) ? MODE_PD : (r < 8) ? MODE_STEP : (r < 9) ? MODE_FIXED : MODE_RESERVED;
      reg_pos = 16'(int'($urandom_range(0, 4000)) - 2000);
      top = int'(reg_pos) + int'($urandom_range(0, 4000));
      max_p = (top > 32767) ? 16'sh7fff : 16'(top);
      if ($urandom_range(0, 7) == 0) max_p = 16'($urandom);
      if (ph == 0) begin
        write_config(MODE_PD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      end else if (ph == 1) begin
        write_config(MODE_STEP, random_gain(), random_gain(), 16'sh8000, 16'sh7fff);
      end else begin
        write_config(mode, random_gain(), random_gain(), reg_pos, max_p);
      end
      // Every third phase runs with no sender gaps, every fourth with no stalls.
      tx_idle_en = (ph % 3) != 2;
      rx_idle_en = (ph % 4) != 3;
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        act = 2'($urandom_range(0, 3));
        enter = (mode_q == MODE_STEP) ? ($urandom_range(0, 15) == 0)
                                      : ($urandom_range(0, 31) == 0);
        send_word(random_error(), act, enter);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver holds off while words keep coming, so the block must fill
  // both of its registers and drop in_ready_o without losing a word.
  task automatic test_backpressure();
    write_config(MODE_PD, random_gain(), random_gain(), -16'sd3000, 16'sd3000);
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int unsigned n = 0; n < 40; n++) begin
      send_word(random_error(), 2'($urandom_range(0, 3)), 1'b0);
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_fixed_modes();
    test_pd_directed();
    test_step_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (pending_commands.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d commands never arrived", $time, pending_commands.size());
    end
    $display("Covered fixed, PD and step modes with clamping, enter loads and stalls:");
    $display("  %0d words sent, %0d commands checked, %0d mismatches.", words_sent,
             commands_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== incremental_pd_accel_controller_core.f =====
sv/ipdac_pkg.sv
sv/incremental_pd_accel_controller_core.sv
bench/testbench.sv
